// ----- sv/sssd_pkg.sv -----
// Shared widths, command codes, reset values and the digit font of the scan dimmer.
package sssd_pkg;

  localparam int NUMBER_W = 16;
  localparam int DIGIT_W  = 4;
  localparam int SEL_W    = 4;
  localparam int SEG_W    = 8;
  localparam int BRIGHT_W = 8;

  localparam int NUM_DIGITS_DEF = 4;
  localparam int DIM_STEPS_DEF  = 8;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 8'd4;
  localparam logic [DIGIT_W-1:0]  DIGIT_MAX    = 4'd9;
  localparam logic [DIGIT_W-1:0]  DIGIT_ZERO   = 4'd0;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

  // Powers of ten for the constant divisors of the digit split
  function automatic longint unsigned pow10(input int k);
    longint unsigned p;
    p = 64'd1;
    for (int i = 0; i < k; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  // Active-low font; anything above nine shows as zero
  function automatic logic [SEG_W-1:0] seg_font(input logic [DIGIT_W-1:0] v);
    logic [SEG_W-1:0] f;
    unique case (v)
      4'd0:    f = 8'h30;
      4'd1:    f = 8'hF9;
      4'd2:    f = 8'h52;
      4'd3:    f = 8'hD0;
      4'd4:    f = 8'h99;
      4'd5:    f = 8'h94;
      4'd6:    f = 8'h14;
      4'd7:    f = 8'hF1;
      4'd8:    f = 8'h10;
      4'd9:    f = 8'h90;
      default: f = 8'h30;
    endcase
    return f;
  endfunction

endpackage

// ----- sv/seven_segment_scan_dimmer_top.sv -----
// Top level of the multiplexed seven-segment scan driver with phase dimming.
//
//   channel  handshake            beat payload
//   in       in_valid / in_stall  in_cmd, in_number
//   out      out_valid/out_stall  out_digit_select, out_segments
//   cfg      cfg_valid/cfg_ready  cfg_brightness
//
// One item per cycle while no tick is stalled: a beat is held in the input register, then a
// load writes the digit registers and a tick writes the result register.
// A tick's result is registered as its beat leaves the input register and can leave at the next edge.
// Loads never wait; a tick waits only while a held result is stalled.
// Synchronous active-low reset: counters zero, digits zero, brightness four.
module seven_segment_scan_dimmer_top #(
  parameter int NUM_DIGITS = sssd_pkg::NUM_DIGITS_DEF,
  parameter int DIM_STEPS  = sssd_pkg::DIM_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [sssd_pkg::NUMBER_W-1:0]  in_number,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sssd_pkg::SEL_W-1:0]     out_digit_select,
  output logic [sssd_pkg::SEG_W-1:0]     out_segments,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sssd_pkg::BRIGHT_W-1:0]  cfg_brightness
);
  import sssd_pkg::*;

  localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int PH_W  = $clog2(DIM_STEPS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_DIGITS - 1);
  localparam logic [PH_W-1:0]  PH_LAST  = PH_W'(DIM_STEPS - 1);

  logic                                in_valid_r;
  cmd_t                                in_cmd_r;
  logic [NUMBER_W-1:0]                 in_number_r;
  logic [IDX_W-1:0]                    digit_idx_r, digit_idx_nxt;
  logic [PH_W-1:0]                     dim_phase_r, dim_phase_nxt;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digit_values_r;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  split_digits;
  logic [BRIGHT_W-1:0]                 brightness_r;
  logic                                out_valid_r;
  logic [SEL_W-1:0]                    out_sel_r, out_sel_nxt;
  logic [SEG_W-1:0]                    out_seg_r, out_seg_nxt;

  logic out_free, advance, take_in, is_tick, is_load, lit;

  sssd_split #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_split (
    .number (in_number_r),
    .digits (split_digits)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && ((in_cmd_r == CMD_LOAD) || out_free);
  assign in_stall = in_valid_r && !advance;
  assign take_in  = in_valid && !in_stall;
  assign is_tick  = advance && (in_cmd_r == CMD_TICK);
  assign is_load  = advance && (in_cmd_r == CMD_LOAD);

  assign cfg_ready = 1'b1;

  // Scan tick: select, font, then advance index and dimming phase
  always_comb begin
    lit         = ({{(BRIGHT_W-PH_W){1'b0}}, dim_phase_r} < brightness_r);
    out_seg_nxt = seg_font(digit_values_r[digit_idx_r]);
    for (int b = 0; b < SEL_W; b++) begin
      out_sel_nxt[b] = lit && (b < NUM_DIGITS) && (4'(digit_idx_r) == 4'(b));
    end
    if (digit_idx_r == IDX_LAST) begin
      digit_idx_nxt = '0;
      dim_phase_nxt = (dim_phase_r == PH_LAST) ? '0 : dim_phase_r + PH_W'(1);
    end else begin
      digit_idx_nxt = digit_idx_r + IDX_W'(1);
      dim_phase_nxt = dim_phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      digit_idx_r    <= '0;
      dim_phase_r    <= '0;
      digit_values_r <= '0;
      brightness_r   <= BRIGHT_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      if (take_in) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (is_load) begin
        digit_values_r <= split_digits;
      end
      if (is_tick) begin
        digit_idx_r <= digit_idx_nxt;
        dim_phase_r <= dim_phase_nxt;
      end
      if (is_tick) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        brightness_r <= cfg_brightness;
      end
    end
  end

  // Payload registers: hold unless a new beat lands
  always_ff @(posedge clk) begin
    if (take_in) begin
      in_cmd_r    <= cmd_t'(in_cmd);
      in_number_r <= in_number;
    end
    if (is_tick) begin
      out_sel_r <= out_sel_nxt;
      out_seg_r <= out_seg_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digit_select = out_sel_r;
  assign out_segments     = out_seg_r;

endmodule

// ----- sv/sssd_split.sv -----
// Decimal digit split of a binary number by reciprocal multiplication.
module sssd_split #(
  parameter int NUM_DIGITS = sssd_pkg::NUM_DIGITS_DEF
) (
  input  logic [sssd_pkg::NUMBER_W-1:0]                  number,
  output logic [NUM_DIGITS-1:0][sssd_pkg::DIGIT_W-1:0]   digits
);
  import sssd_pkg::*;

  // quot[k] = number / 10^k; quot[0] is the number itself, each higher one from its own multiply
  logic [NUMBER_W-1:0] quot [NUM_DIGITS];

  assign quot[0] = number;

  for (genvar k = 1; k < NUM_DIGITS; k++) begin : g_quot
    localparam longint unsigned DIV   = pow10(k);
    localparam int              SH    = NUMBER_W + $clog2(DIV);
    localparam longint unsigned RECIP = ((64'd1 << SH) + DIV - 64'd1) / DIV;
    localparam logic [NUMBER_W:0] RECIP_C = (NUMBER_W+1)'(RECIP);
    logic [2*NUMBER_W:0] prod;
    assign prod    = (2*NUMBER_W+1)'(number) * (2*NUMBER_W+1)'(RECIP_C);
    assign quot[k] = NUMBER_W'(prod >> SH);
  end

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_digit
    localparam int K = NUM_DIGITS - 1 - i;
    if (i == 0) begin : g_top
      // blank an oversized top digit to zero
      assign digits[i] = (quot[K] > NUMBER_W'(DIGIT_MAX)) ? DIGIT_ZERO
                                                          : quot[K][DIGIT_W-1:0];
    end else begin : g_rem
      logic [NUMBER_W-1:0] rem;
      assign rem       = quot[K] - ((quot[K+1] << 3) + (quot[K+1] << 1));
      assign digits[i] = rem[DIGIT_W-1:0];
    end
  end

endmodule
